// File: design/hcbp_pkg.sv
package hcbp_pkg;

    localparam int MAX_CODE_LEN_DEF = 16;
    localparam int SYMBOL_COUNT_DEF = 256;
    localparam int MODE_W           = 2;
    localparam int SYM_W            = 8;
    localparam int CODE_W           = 16;
    localparam int LEN_W            = 5;
    localparam int BYTE_W           = 8;
    localparam int ACC_W            = 24;
    localparam int QUEUE_DEPTH      = 4;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD   = 2'd0,
        MODE_ENCODE = 2'd1,
        MODE_FLUSH  = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CMD_ENCODE = 2'd0,
        CMD_FLUSH  = 2'd1,
        CMD_ERROR  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [CODE_W-1:0]  code;
        logic [LEN_W-1:0]   len;
    } cmd_t;

endpackage

// File: design/hcbp_ram.sv
module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/hcbp_front.sv
module hcbp_front #(
    parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
    parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [hcbp_pkg::MODE_W-1:0]   mode,
    input  logic [hcbp_pkg::SYM_W-1:0]    symbol,
    input  logic [hcbp_pkg::CODE_W-1:0]   code_bits,
    input  logic [hcbp_pkg::LEN_W-1:0]    code_length,
    input  logic                          q_full,
    output logic                          q_push,
    output hcbp_pkg::cmd_t                q_din
);

    localparam int ADDR_W  = $clog2(SYMBOL_COUNT);
    localparam int CAP     = (MAX_CODE_LEN < hcbp_pkg::CODE_W) ? MAX_CODE_LEN
                                                                : hcbp_pkg::CODE_W;
    localparam int ENTRY_W = hcbp_pkg::LEN_W + hcbp_pkg::CODE_W;

    logic [SYMBOL_COUNT-1:0]       entry_valid_reg;
    logic                          st1_valid_reg;
    hcbp_pkg::cmd_kind_t           st1_kind_reg;

    logic                          accept;
    logic                          in_range;
    logic [ADDR_W-1:0]             addr;
    logic                          hit;
    logic                          load_we;
    logic                          rd_en;
    logic                          takes_cmd;
    logic [hcbp_pkg::LEN_W-1:0]    lim_len;
    logic [hcbp_pkg::LEN_W-1:0]    rd_len;
    logic [ENTRY_W-1:0]            wdata;
    logic [ENTRY_W-1:0]            rdata;

    assign accept    = s_tvalid && s_tready;
    assign in_range  = {1'b0, symbol} < (hcbp_pkg::SYM_W + 1)'(SYMBOL_COUNT);
    assign addr      = symbol[ADDR_W-1:0];
    assign hit       = in_range && entry_valid_reg[addr];
    assign load_we   = accept && (mode == hcbp_pkg::MODE_LOAD) && in_range;
    assign rd_en     = accept && (mode == hcbp_pkg::MODE_ENCODE) && hit;
    assign takes_cmd = (mode == hcbp_pkg::MODE_ENCODE) || (mode == hcbp_pkg::MODE_FLUSH);

    assign lim_len = (code_length > hcbp_pkg::LEN_W'(CAP)) ? hcbp_pkg::LEN_W'(CAP)
                                                            : code_length;
    assign wdata   = {lim_len, code_bits};

    hcbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SYMBOL_COUNT)
    ) u_table (
        .aclk  (aclk),
        .we    (load_we),
        .waddr (addr),
        .wdata (wdata),
        .re    (rd_en),
        .raddr (addr),
        .rdata (rdata)
    );

    // length limit repeated on read, harmless for entries already limited
    assign rd_len = (rdata[ENTRY_W-1:hcbp_pkg::CODE_W] > hcbp_pkg::LEN_W'(CAP))
                  ? hcbp_pkg::LEN_W'(CAP) : rdata[ENTRY_W-1:hcbp_pkg::CODE_W];

    assign s_tready   = !st1_valid_reg || !q_full;
    assign q_push     = st1_valid_reg && !q_full;
    assign q_din.kind = st1_kind_reg;
    assign q_din.code = rdata[hcbp_pkg::CODE_W-1:0];
    assign q_din.len  = rd_len;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
            st1_valid_reg   <= 1'b0;
            st1_kind_reg    <= hcbp_pkg::CMD_FLUSH;
        end else begin
            if (load_we) begin
                entry_valid_reg[addr] <= 1'b1;
            end
            if (accept && takes_cmd) begin
                st1_valid_reg <= 1'b1;
                if (mode == hcbp_pkg::MODE_FLUSH) begin
                    st1_kind_reg <= hcbp_pkg::CMD_FLUSH;
                end else if (hit) begin
                    st1_kind_reg <= hcbp_pkg::CMD_ENCODE;
                end else begin
                    st1_kind_reg <= hcbp_pkg::CMD_ERROR;
                end
            end else if (q_push) begin
                st1_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: design/hcbp_queue.sv
module hcbp_queue #(
    parameter int DEPTH = hcbp_pkg::QUEUE_DEPTH
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  hcbp_pkg::cmd_t             din,
    output logic                       full,
    input  logic                       pop,
    output hcbp_pkg::cmd_t             dout,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    hcbp_pkg::cmd_t    mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem_reg[rd_ptr_reg];
    assign count = count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: design/hcbp_back.sv
module hcbp_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_empty,
    input  hcbp_pkg::cmd_t              q_dout,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [hcbp_pkg::BYTE_W-1:0] m_tdata,
    output logic                        m_tlast,
    output logic                        m_tuser,
    output logic                        pend_valid
);

    localparam int ACC_W = hcbp_pkg::ACC_W;
    localparam int LEN_W = hcbp_pkg::LEN_W;
    localparam int BW    = hcbp_pkg::BYTE_W;

    logic [BW-1:0]     partial_reg,  partial_next;
    logic [2:0]        count_reg,    count_next;
    logic              out_valid_reg, out_valid_next;
    logic [BW-1:0]     out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;
    logic              out_err_reg,  out_err_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [BW-1:0]     pend_byte_reg, pend_byte_next;

    logic              out_free;
    logic [ACC_W-1:0]  code_ext;
    logic [ACC_W-1:0]  code_mask;
    logic [LEN_W-1:0]  shamt;
    logic [ACC_W-1:0]  acc;
    logic [LEN_W-1:0]  total;
    logic [1:0]        nbytes;

    assign out_free = !out_valid_reg || m_tready;
    assign q_pop    = !q_empty && !pend_valid_reg && out_free;

    // new bits land just below the bits already held in the partial byte
    assign code_mask = ~({ACC_W{1'b1}} << q_dout.len);
    assign code_ext  = {{(ACC_W - hcbp_pkg::CODE_W){1'b0}}, q_dout.code} & code_mask;
    assign shamt     = LEN_W'(ACC_W) - {2'b00, count_reg} - q_dout.len;
    assign acc       = {partial_reg, {(ACC_W - BW){1'b0}}} | (code_ext << shamt);
    assign total     = {2'b00, count_reg} + q_dout.len;
    assign nbytes    = total[4:3];

    always_comb begin
        partial_next    = partial_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_err_next    = out_err_reg;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;

        if (out_free) begin
            out_valid_next = 1'b0;
        end
        if (pend_valid_reg && out_free) begin
            out_valid_next  = 1'b1;
            out_byte_next   = pend_byte_reg;
            out_last_next   = 1'b1;
            out_err_next    = 1'b0;
            pend_valid_next = 1'b0;
        end

        if (q_pop) begin
            unique case (q_dout.kind)
                hcbp_pkg::CMD_ENCODE: begin
                    count_next = total[2:0];
                    case (nbytes)
                        2'd0: begin
                            partial_next = acc[23:16];
                        end
                        2'd1: begin
                            out_valid_next = 1'b1;
                            out_byte_next  = acc[23:16];
                            out_last_next  = 1'b1;
                            out_err_next   = 1'b0;
                            partial_next   = acc[15:8];
                        end
                        default: begin
                            out_valid_next  = 1'b1;
                            out_byte_next   = acc[23:16];
                            out_last_next   = 1'b0;
                            out_err_next    = 1'b0;
                            pend_valid_next = 1'b1;
                            pend_byte_next  = acc[15:8];
                            partial_next    = acc[7:0];
                        end
                    endcase
                end
                hcbp_pkg::CMD_FLUSH: begin
                    if (count_reg != 3'd0) begin
                        out_valid_next = 1'b1;
                        out_byte_next  = partial_reg;
                        out_last_next  = 1'b1;
                        out_err_next   = 1'b0;
                    end
                    partial_next = '0;
                    count_next   = '0;
                end
                hcbp_pkg::CMD_ERROR: begin
                    out_valid_next = 1'b1;
                    out_byte_next  = '0;
                    out_last_next  = 1'b1;
                    out_err_next   = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg    <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            partial_reg    <= partial_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
        out_err_reg   <= out_err_next;
        pend_byte_reg <= pend_byte_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_byte_reg;
    assign m_tlast    = out_last_reg;
    assign m_tuser    = out_err_reg;
    assign pend_valid = pend_valid_reg;

endmodule

// File: design/huffman_code_bit_packer_unit.sv
// Huffman code table and MSB-first bit packer.
// Input stream: s_tuser carries the mode (load entry, encode, flush), s_tdata
// the symbol, code bits and code length. Loads write the code table and give
// no output; encodes append the symbol's code to the current byte; a flush
// pads and emits the partial byte if it holds bits.
// Output stream: up to two bytes per request, first bit in bit 7. m_tlast marks the
// final byte caused by an input request, m_tuser flags a symbol with no code
// (byte zero, no change to the packer).
// A request's bytes pass the lookup register, command queue and output register.
// Throughput: one request per cycle while m_tready is high; an encode that completes
// two bytes stalls until its second byte enters the single-byte output register.
// Table lookup uses a registered-read RAM; entry valid bits are flip-flops.
// Reset clears valid bits, partial byte and fill count; table
// contents are kept. When m_tready is low, output holds, the command queue
// fills, and s_tready drops once the queue and lookup stage are full.
module huffman_code_bit_packer_unit #(
    parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
    parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // symbol[7:0], code_bits[23:8], code_length[28:24]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte[7:0]
    output logic        m_tlast,
    output logic [0:0]  m_tuser    // error[0]
);

    localparam int CNT_W = $clog2(hcbp_pkg::QUEUE_DEPTH + 1);

    logic              q_full;
    logic              q_push;
    hcbp_pkg::cmd_t    q_din;
    logic              q_pop;
    hcbp_pkg::cmd_t    q_dout;
    logic              q_empty;
    logic [CNT_W-1:0]  q_count;
    logic              pend_valid;

    hcbp_front #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .mode        (s_tuser),
        .symbol      (s_tdata[7:0]),
        .code_bits   (s_tdata[23:8]),
        .code_length (s_tdata[28:24]),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_din       (q_din)
    );

    hcbp_queue #(
        .DEPTH (hcbp_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_din),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (q_dout),
        .empty   (q_empty),
        .count   (q_count)
    );

    hcbp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .q_dout     (q_dout),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser[0]),
        .pend_valid (pend_valid)
    );

    a_error_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast && (m_tdata == 8'h00))
        else $error("error request not a single zero byte");

    a_first_of_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> pend_valid)
        else $error("non-last byte without its second byte pending");

    a_pend_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid |-> m_tvalid)
        else $error("pending byte with empty output register");

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= CNT_W'(hcbp_pkg::QUEUE_DEPTH) && (q_empty == (q_count == '0)))
        else $error("command queue count out of range");

endmodule

// File: bench/huffman_code_bit_packer_unit_tb.sv
`timescale 1ns / 1ps

module huffman_code_bit_packer_unit_tb;

    localparam int LEN_CAP        = (hcbp_pkg::MAX_CODE_LEN_DEF < hcbp_pkg::CODE_W)
                                  ? hcbp_pkg::MAX_CODE_LEN_DEF : hcbp_pkg::CODE_W;
    localparam int RANDOM_ITEMS   = 160;
    localparam int HOLD_CYCLES    = 120;
    localparam int DRAIN_CYCLES   = 24;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       err;
    } packed_byte_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = hcbp_pkg::MODE_LOAD;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;

    // expected output stream and packer shadow state
    packed_byte_t pending_bytes[$];
    logic [4:0]   code_len_tbl  [hcbp_pkg::SYMBOL_COUNT_DEF];
    logic [15:0]  code_bits_tbl [hcbp_pkg::SYMBOL_COUNT_DEF];
    logic         code_loaded   [hcbp_pkg::SYMBOL_COUNT_DEF];
    logic [7:0]   fill_byte;
    int           fill_count;
    logic [7:0]   loaded_syms[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;
    int hold_left      = 0;
    int fail_count     = 0;
    int idle_cycles    = 0;

    huffman_code_bit_packer_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #6 aclk = ~aclk;

    task automatic flag_failure(string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    function automatic void pack_request(hcbp_pkg::mode_t mode, logic [7:0] sym,
                                         logic [15:0] code, logic [4:0] len);
        packed_byte_t done_bytes [2];
        int           n_done;
        int           bit_idx;
        n_done = 0;
        case (mode)
            hcbp_pkg::MODE_LOAD: begin
                code_len_tbl[sym]  = (len > LEN_CAP) ? 5'(LEN_CAP) : len;
                code_bits_tbl[sym] = code;
                code_loaded[sym]   = 1'b1;
            end
            hcbp_pkg::MODE_ENCODE: begin
                if (!code_loaded[sym]) begin
                    pending_bytes.push_back('{out_byte: 8'h00, last: 1'b1, err: 1'b1});
                end else begin
                    for (bit_idx = int'(code_len_tbl[sym]) - 1; bit_idx >= 0; bit_idx--) begin
                        if (code_bits_tbl[sym][bit_idx]) begin
                            fill_byte[7 - fill_count] = 1'b1;
                        end
                        fill_count++;
                        if (fill_count == hcbp_pkg::BYTE_W) begin
                            done_bytes[n_done] = '{out_byte: fill_byte, last: 1'b0, err: 1'b0};
                            n_done++;
                            fill_byte  = '0;
                            fill_count = 0;
                        end
                    end
                    if (n_done > 0) begin
                        done_bytes[n_done - 1].last = 1'b1;
                    end
                    for (int k = 0; k < n_done; k++) begin
                        pending_bytes.push_back(done_bytes[k]);
                    end
                end
            end
            hcbp_pkg::MODE_FLUSH: begin
                if (fill_count > 0) begin
                    pending_bytes.push_back('{out_byte: fill_byte, last: 1'b1, err: 1'b0});
                    fill_byte  = '0;
                    fill_count = 0;
                end
            end
            default: begin
            end
        endcase
    endfunction

    // called at a falling edge, returns at a falling edge with tvalid still high
    task automatic send_request(hcbp_pkg::mode_t mode, logic [7:0] sym, logic [15:0] code,
                                logic [4:0] len);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {3'b000, len, code, sym};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        pack_request(mode, sym, code, len);
        if (mode == hcbp_pkg::MODE_LOAD) begin
            loaded_syms.push_back(sym);
        end
        @(negedge aclk);
    endtask

    task automatic send_random_request(output bit counted);
        int         pick;
        int         len_pick;
        logic [7:0] sym;
        logic [4:0] len;
        pick    = $urandom_range(99);
        sym     = 8'($urandom);
        counted = 1'b1;
        if (pick < 22) begin
            len_pick = $urandom_range(99);
            if (len_pick < 5) begin
                len = 5'd0;
            end else if (len_pick < 12) begin
                len = 5'($urandom_range(31, LEN_CAP + 1));
            end else begin
                len = 5'($urandom_range(LEN_CAP, 1));
            end
            send_request(hcbp_pkg::MODE_LOAD, sym, 16'($urandom), len);
        end else if (pick < 82) begin
            if (loaded_syms.size() > 0 && $urandom_range(99) < 88) begin
                sym = loaded_syms[$urandom_range(loaded_syms.size() - 1)];
            end
            send_request(hcbp_pkg::MODE_ENCODE, sym, 16'($urandom), 5'($urandom));
        end else if (pick < 95) begin
            send_request(hcbp_pkg::MODE_FLUSH, sym, 16'($urandom), 5'($urandom));
        end else begin
            counted = 1'b0;
            send_request(hcbp_pkg::MODE_NONE, sym, 16'($urandom), 5'($urandom));
        end
    endtask

    task automatic test_directed();
        send_request(hcbp_pkg::MODE_ENCODE, 8'h00, 16'h0000, 5'd0);  // no code loaded
        send_request(hcbp_pkg::MODE_FLUSH,  8'h00, 16'h0000, 5'd0);  // nothing held
        send_request(hcbp_pkg::MODE_NONE,   8'hFF, 16'hFFFF, 5'h1F);
        send_request(hcbp_pkg::MODE_LOAD,   8'h00, 16'hFFFF, 5'd16);
        send_request(hcbp_pkg::MODE_LOAD,   8'hFF, 16'h0000, 5'd0);  // zero length
        send_request(hcbp_pkg::MODE_LOAD,   8'h5A, 16'h0005, 5'd3);
        send_request(hcbp_pkg::MODE_LOAD,   8'hA5, 16'hABCD, 5'd31); // saturates
        send_request(hcbp_pkg::MODE_LOAD,   8'h01, 16'h0001, 5'd1);
        send_request(hcbp_pkg::MODE_ENCODE, 8'h00, 16'h0000, 5'd0);
        send_request(hcbp_pkg::MODE_ENCODE, 8'hFF, 16'hFFFF, 5'h1F);
        send_request(hcbp_pkg::MODE_ENCODE, 8'h5A, 16'h0000, 5'd0);
        send_request(hcbp_pkg::MODE_ENCODE, 8'h99, 16'h0000, 5'd0);  // missing, state kept
        send_request(hcbp_pkg::MODE_ENCODE, 8'hA5, 16'h0000, 5'd0);
        send_request(hcbp_pkg::MODE_ENCODE, 8'h01, 16'h0000, 5'd0);
        send_request(hcbp_pkg::MODE_FLUSH,  8'h00, 16'h0000, 5'd0);
        send_request(hcbp_pkg::MODE_FLUSH,  8'h00, 16'h0000, 5'd0);
        send_request(hcbp_pkg::MODE_LOAD,   8'h5A, 16'h1234, 5'd17);
        send_request(hcbp_pkg::MODE_ENCODE, 8'h5A, 16'h0000, 5'd0);
        send_request(hcbp_pkg::MODE_ENCODE, 8'h01, 16'h0000, 5'd0);
        send_request(hcbp_pkg::MODE_ENCODE, 8'h00, 16'h0000, 5'd0);
        send_request(hcbp_pkg::MODE_FLUSH,  8'hFF, 16'hFFFF, 5'h1F);
    endtask

    task automatic test_random_stream(int idle_pct, int stall_pct);
        int n_sent;
        bit counted;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        n_sent         = 0;
        while (n_sent < RANDOM_ITEMS) begin
            send_random_request(counted);
            if (counted) begin
                n_sent++;
            end
        end
    endtask

    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_request(hcbp_pkg::MODE_LOAD, 8'h3C, 16'($urandom), 5'd16);
        hold_req = 1'b1;
        for (int k = 0; k < 30; k++) begin
            send_request(hcbp_pkg::MODE_ENCODE, (k % 5 == 4) ? 8'h5A : 8'h3C, 16'h0000, 5'd0);
        end
    endtask

    // result side: random stalls plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        packed_byte_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_bytes.size() == 0) begin
                flag_failure($sformatf("unexpected byte %02h last %0b err %0b",
                                       m_tdata, m_tlast, m_tuser[0]));
            end else begin
                want = pending_bytes.pop_front();
                if (m_tdata !== want.out_byte || m_tlast !== want.last ||
                    m_tuser[0] !== want.err) begin
                    flag_failure($sformatf(
                        "mismatch: expected byte %02h last %0b err %0b, got %02h %0b %0b",
                        want.out_byte, want.last, want.err, m_tdata, m_tlast, m_tuser[0]));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        for (int k = 0; k < hcbp_pkg::SYMBOL_COUNT_DEF; k++) begin
            code_loaded[k]   = 1'b0;
            code_len_tbl[k]  = '0;
            code_bits_tbl[k] = '0;
        end
        fill_byte  = '0;
        fill_count = 0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_random_stream(0, 0);
        test_output_backpressure();
        test_random_stream(50, 0);
        test_random_stream(0, 50);
        test_random_stream(28, 28);
        s_tvalid <= 1'b0;

        while (pending_bytes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
design/hcbp_pkg.sv
design/hcbp_ram.sv
design/hcbp_front.sv
design/hcbp_queue.sv
design/hcbp_back.sv
design/huffman_code_bit_packer_unit.sv
bench/huffman_code_bit_packer_unit_tb.sv
